[rtl/core/apc_pkg.sv]
package apc_pkg;

	localparam int COORD_W  = 32;
	localparam int HALF_W   = COORD_W - 1;
	localparam int NRM_FRAC = 14;
	localparam int NRM_W    = NRM_FRAC + 2;
	localparam int QBITS    = NRM_FRAC + 1;
	localparam int MAG_W    = COORD_W;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int SUM_W    = SQ_W + 2;
	localparam int R_SHIFT  = 2 * NRM_FRAC + 2;
	localparam int RES_W    = SQ_W + R_SHIFT + 6;
	localparam int T_W      = SUM_W + QBITS + 3;
	localparam int PROD_W   = QBITS + HALF_W;

	typedef struct packed {
		logic signed [RES_W-1:0] res;
		logic signed [T_W-1:0]   t;
		logic [QBITS-1:0]        q;
		logic                    neg;
		logic [HALF_W-1:0]       ha;
		logic [HALF_W-1:0]       hb;
	} apc_lane_t;

	typedef struct packed {
		logic              hit;
		logic              any;
		logic [SUM_W-1:0]  s;
		apc_lane_t [2:0]   ax;
	} apc_item_t;

endpackage

[rtl/core/aabb_pair_contact.sv]
// Overlap test and contact data for one pair of axis-aligned boxes.
// Input channel (in_valid/in_ready): centres of boxes A and B (signed Q16.16)
// and their half-extents (unsigned Q15.16), one pair per request.
// Output channel (out_valid/out_ready): hit flag, unit normal from B to A
// (Q2.14) and contact offsets for A and B (Q16.16); all zero without a hit,
// and zero normal and offsets with hit when the centres coincide.
// The pipeline has 3 front stages (difference, squares, sum),
// 15 normal stages (one quotient bit per stage, all three axes in
// parallel), and 2 contact stages (product, round and sign).
// Throughput is one request per cycle while out_ready is high.
// When the receiver stalls, the whole pipeline holds and in_ready drops;
// nothing is dropped or repeated. Reset empties the pipeline at once.
module aabb_pair_contact import apc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] box_a_center_x,
	input  logic signed [COORD_W-1:0] box_a_center_y,
	input  logic signed [COORD_W-1:0] box_a_center_z,
	input  logic signed [COORD_W-1:0] box_b_center_x,
	input  logic signed [COORD_W-1:0] box_b_center_y,
	input  logic signed [COORD_W-1:0] box_b_center_z,
	input  logic [HALF_W-1:0]         box_a_half_x,
	input  logic [HALF_W-1:0]         box_a_half_y,
	input  logic [HALF_W-1:0]         box_a_half_z,
	input  logic [HALF_W-1:0]         box_b_half_x,
	input  logic [HALF_W-1:0]         box_b_half_y,
	input  logic [HALF_W-1:0]         box_b_half_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      hit,
	output logic signed [NRM_W-1:0]   normal_x,
	output logic signed [NRM_W-1:0]   normal_y,
	output logic signed [NRM_W-1:0]   normal_z,
	output logic signed [COORD_W-1:0] contact_a_x,
	output logic signed [COORD_W-1:0] contact_a_y,
	output logic signed [COORD_W-1:0] contact_a_z,
	output logic signed [COORD_W-1:0] contact_b_x,
	output logic signed [COORD_W-1:0] contact_b_y,
	output logic signed [COORD_W-1:0] contact_b_z
);

	logic                    en, v_f, v_n;
	apc_item_t               item_f, item_n;
	logic [2:0][NRM_W-1:0]   nrm;
	logic [2:0][COORD_W-1:0] ca, cb;

	assign en       = !(out_valid && !out_ready);
	assign in_ready = en;

	apc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (in_valid),
		.ctr_a  ({box_a_center_z, box_a_center_y, box_a_center_x}),
		.ctr_b  ({box_b_center_z, box_b_center_y, box_b_center_x}),
		.half_a ({box_a_half_z, box_a_half_y, box_a_half_x}),
		.half_b ({box_b_half_z, box_b_half_y, box_b_half_x}),
		.v_o    (v_f),
		.item_o (item_f)
	);

	apc_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (v_f),
		.item_i (item_f),
		.v_o    (v_n),
		.item_o (item_n)
	);

	apc_contact u_contact (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (v_n),
		.item_i (item_n),
		.v_o    (out_valid),
		.hit_o  (hit),
		.nrm_o  (nrm),
		.ca_o   (ca),
		.cb_o   (cb)
	);

	assign normal_x    = nrm[0];
	assign normal_y    = nrm[1];
	assign normal_z    = nrm[2];
	assign contact_a_x = ca[0];
	assign contact_a_y = ca[1];
	assign contact_a_z = ca[2];
	assign contact_b_x = cb[0];
	assign contact_b_y = cb[1];
	assign contact_b_z = cb[2];

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> normal_x == '0 && normal_y == '0 && normal_z == '0
			&& contact_a_x == '0 && contact_b_x == '0)
		else $error("miss with nonzero normal or contact");

	a_nrm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384)
		else $error("normal out of unit range");

	a_contact_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && normal_y == '0 |-> contact_a_y == '0 && contact_b_y == '0)
		else $error("contact without normal component");

endmodule

[rtl/core/apc_front.sv]
module apc_front import apc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_i,
	input  logic [2:0][COORD_W-1:0]     ctr_a,
	input  logic [2:0][COORD_W-1:0]     ctr_b,
	input  logic [2:0][HALF_W-1:0]      half_a,
	input  logic [2:0][HALF_W-1:0]      half_b,
	output logic                        v_o,
	output apc_item_t                   item_o
);

	logic [2:0][COORD_W:0]  d_c;
	logic [2:0][COORD_W:0]  mag_c;
	logic [2:0][HALF_W:0]   sum_c;
	logic                   hit_c, any_c;

	logic                   v_s1, v_s2, v_s3;
	logic [2:0][MAG_W-1:0]  mag_s1;
	logic [2:0]             neg_s1, neg_s2;
	logic [2:0][HALF_W-1:0] ha_s1, hb_s1, ha_s2, hb_s2;
	logic                   hit_s1, any_s1, hit_s2, any_s2;
	logic [2:0][SQ_W-1:0]   sq_s2;
	apc_item_t              item_s3;
	logic [SUM_W-1:0]       s_c;

	always_comb begin
		hit_c = 1'b1;
		any_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			d_c[i]   = {ctr_a[i][COORD_W-1], ctr_a[i]} - {ctr_b[i][COORD_W-1], ctr_b[i]};
			mag_c[i] = d_c[i][COORD_W] ? (~d_c[i] + 1'b1) : d_c[i];
			sum_c[i] = {1'b0, half_a[i]} + {1'b0, half_b[i]};
			if (mag_c[i] > {1'b0, sum_c[i]})
				hit_c = 1'b0;
			if (mag_c[i] != '0)
				any_c = 1'b1;
		end
		s_c = SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag_c[i][MAG_W-1:0];
				neg_s1[i] <= d_c[i][COORD_W];
				sq_s2[i]  <= SQ_W'(mag_s1[i]) * SQ_W'(mag_s1[i]);
				item_s3.ax[i].res <= $signed(RES_W'(sq_s2[i]) << R_SHIFT) - $signed(RES_W'(s_c));
				item_s3.ax[i].t   <= -$signed(T_W'(s_c));
				item_s3.ax[i].q   <= '0;
				item_s3.ax[i].neg <= neg_s2[i];
				item_s3.ax[i].ha  <= ha_s2[i];
				item_s3.ax[i].hb  <= hb_s2[i];
			end
			ha_s1   <= half_a;
			hb_s1   <= half_b;
			hit_s1  <= hit_c;
			any_s1  <= any_c;
			neg_s2  <= neg_s1;
			ha_s2   <= ha_s1;
			hb_s2   <= hb_s1;
			hit_s2  <= hit_s1;
			any_s2  <= any_s1;
			item_s3.hit <= hit_s2;
			item_s3.any <= any_s2;
			item_s3.s   <= s_c;
		end
	end

	assign v_o    = v_s3;
	assign item_o = item_s3;

endmodule

[rtl/core/apc_norm.sv]
module apc_norm import apc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      v_i,
	input  apc_item_t item_i,
	output logic      v_o,
	output apc_item_t item_o
);

	apc_item_t        step_s [1:QBITS];
	logic             vstep_s [1:QBITS];

	for (genvar j = 0; j < QBITS; j++) begin : g_step
		localparam int K = QBITS - 1 - j;
		apc_item_t                src, nx;
		logic                     vsrc;
		logic signed [RES_W-1:0]  cand [3];

		if (j == 0) begin : g_head
			assign src  = item_i;
			assign vsrc = v_i;
		end else begin : g_body
			assign src  = step_s[j];
			assign vsrc = vstep_s[j];
		end

		always_comb begin
			nx = src;
			for (int i = 0; i < 3; i++) begin
				cand[i] = src.ax[i].res
					- ($signed(RES_W'($signed(src.ax[i].t))) <<< (K + 2))
					- $signed(RES_W'(src.s) << (2 * K + 2));
				if (!cand[i][RES_W-1]) begin
					nx.ax[i].res  = cand[i];
					nx.ax[i].t    = src.ax[i].t + $signed(T_W'(src.s) << (K + 1));
					nx.ax[i].q[K] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vstep_s[j+1] <= 1'b0;
			else if (en)
				vstep_s[j+1] <= vsrc;
		end

		always_ff @(posedge clk) begin
			if (en)
				step_s[j+1] <= nx;
		end
	end

	assign v_o    = vstep_s[QBITS];
	assign item_o = step_s[QBITS];

endmodule

[rtl/core/apc_contact.sv]
module apc_contact import apc_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          v_i,
	input  apc_item_t                     item_i,
	output logic                          v_o,
	output logic                          hit_o,
	output logic [2:0][NRM_W-1:0]         nrm_o,
	output logic [2:0][COORD_W-1:0]       ca_o,
	output logic [2:0][COORD_W-1:0]       cb_o
);

	logic                    v_s1, v_s2, hit_s1, zero_s1, hit_s2;
	logic [2:0][QBITS-1:0]   q_s1;
	logic [2:0]              neg_s1;
	logic [2:0][PROD_W-1:0]  pa_s1, pb_s1;
	logic [2:0][NRM_W-1:0]   nrm_s2;
	logic [2:0][COORD_W-1:0] ca_s2, cb_s2;
	logic [2:0][PROD_W-1:0]  ra_c, rb_c;
	logic [2:0][COORD_W-1:0] ma_c, mb_c;
	logic [2:0][NRM_W-1:0]   mn_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ra_c[i] = pa_s1[i] + (PROD_W'(1) << (NRM_FRAC - 1));
			rb_c[i] = pb_s1[i] + (PROD_W'(1) << (NRM_FRAC - 1));
			ma_c[i] = ra_c[i][NRM_FRAC +: COORD_W];
			mb_c[i] = rb_c[i][NRM_FRAC +: COORD_W];
			mn_c[i] = NRM_W'(q_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1  <= item_i.hit;
			zero_s1 <= !(item_i.hit && item_i.any);
			for (int i = 0; i < 3; i++) begin
				q_s1[i]   <= item_i.ax[i].q;
				neg_s1[i] <= item_i.ax[i].neg;
				pa_s1[i]  <= PROD_W'(item_i.ax[i].q) * PROD_W'(item_i.ax[i].ha);
				pb_s1[i]  <= PROD_W'(item_i.ax[i].q) * PROD_W'(item_i.ax[i].hb);
				if (zero_s1) begin
					nrm_s2[i] <= '0;
					ca_s2[i]  <= '0;
					cb_s2[i]  <= '0;
				end else begin
					nrm_s2[i] <= neg_s1[i] ? -mn_c[i] : mn_c[i];
					ca_s2[i]  <= neg_s1[i] ? -ma_c[i] : ma_c[i];
					cb_s2[i]  <= neg_s1[i] ? mb_c[i] : -mb_c[i];
				end
			end
			hit_s2 <= hit_s1;
		end
	end

	assign v_o   = v_s2;
	assign hit_o = hit_s2;
	assign nrm_o = nrm_s2;
	assign ca_o  = ca_s2;
	assign cb_o  = cb_s2;

endmodule

[sim/tb_aabb_pair_contact.sv]
`timescale 1ns / 100ps

module tb_aabb_pair_contact import apc_pkg::*;;

	typedef struct {
		logic signed [COORD_W-1:0] ac[3];
		logic signed [COORD_W-1:0] bc[3];
		logic [HALF_W-1:0]         ah[3];
		logic [HALF_W-1:0]         bh[3];
	} box_pair_t;

	typedef struct {
		logic                      hit;
		logic signed [NRM_W-1:0]   nrm[3];
		logic signed [COORD_W-1:0] ca[3];
		logic signed [COORD_W-1:0] cb[3];
	} contact_t;

	class contact_board;
		contact_t pending[$];
		int       mismatches;

		function contact_t contact_of(box_pair_t p);
			contact_t r;
			longint mag[3], ca, cb, lo, hi, mid, t;
			bit neg[3], any;
			logic [127:0] ssq, lhs, rhs;
			r.hit = 1;
			any = 0;
			ssq = 0;
			for (int i = 0; i < 3; i++) begin
				mag[i] = longint'(p.ac[i]) - longint'(p.bc[i]);
				neg[i] = mag[i] < 0;
				if (neg[i])
					mag[i] = -mag[i];
				if (mag[i] > longint'(p.ah[i]) + longint'(p.bh[i]))
					r.hit = 0;
				if (mag[i] != 0)
					any = 1;
				ssq += 128'(mag[i]) * 128'(mag[i]);
				r.nrm[i] = '0;
				r.ca[i] = '0;
				r.cb[i] = '0;
			end
			if (!r.hit || !any)
				return r;
			for (int i = 0; i < 3; i++) begin
				lo = 0;
				hi = 1 << NRM_FRAC;
				rhs = (128'(mag[i]) * 128'(mag[i])) << (2 * NRM_FRAC + 2);
				while (lo < hi) begin
					mid = (lo + hi + 1) >> 1;
					t = 2 * mid - 1;
					lhs = ssq * 128'(t * t);
					if (lhs <= rhs)
						lo = mid;
					else
						hi = mid - 1;
				end
				ca = (lo * longint'(p.ah[i]) + (1 << (NRM_FRAC - 1))) >> NRM_FRAC;
				cb = (lo * longint'(p.bh[i]) + (1 << (NRM_FRAC - 1))) >> NRM_FRAC;
				r.nrm[i] = NRM_W'(neg[i] ? -lo : lo);
				r.ca[i] = COORD_W'(neg[i] ? -ca : ca);
				r.cb[i] = COORD_W'(neg[i] ? cb : -cb);
			end
			return r;
		endfunction

		function void note_request(box_pair_t p);
			pending.insert(pending.size(), contact_of(p));
		endfunction

		function void check_result(contact_t got);
			contact_t want;
			bit bad;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: hit=%0d", got.hit);
				return;
			end
			want = pending.pop_front();
			bad = got.hit !== want.hit;
			for (int i = 0; i < 3; i++)
				if (got.nrm[i] !== want.nrm[i] || got.ca[i] !== want.ca[i]
						|| got.cb[i] !== want.cb[i])
					bad = 1;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp hit=%0d n=%0d,%0d,%0d ca=%0d,%0d,%0d cb=%0d,%0d,%0d | act hit=%0d n=%0d,%0d,%0d ca=%0d,%0d,%0d cb=%0d,%0d,%0d",
						want.hit, want.nrm[0], want.nrm[1], want.nrm[2],
						want.ca[0], want.ca[1], want.ca[2],
						want.cb[0], want.cb[1], want.cb[2],
						got.hit, got.nrm[0], got.nrm[1], got.nrm[2],
						got.ca[0], got.ca[1], got.ca[2],
						got.cb[0], got.cb[1], got.cb[2]);
			end
		endfunction
	endclass

	logic clk, arst_n, in_valid, in_ready, out_valid, out_ready;
	box_pair_t cur;
	logic hit;
	logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;
	logic signed [COORD_W-1:0] contact_a_x, contact_a_y, contact_a_z;
	logic signed [COORD_W-1:0] contact_b_x, contact_b_y, contact_b_z;

	contact_board board;
	bit quiet, hold_req;
	int idle_cycles;

	aabb_pair_contact u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.box_a_center_x(cur.ac[0]), .box_a_center_y(cur.ac[1]),
		.box_a_center_z(cur.ac[2]),
		.box_b_center_x(cur.bc[0]), .box_b_center_y(cur.bc[1]),
		.box_b_center_z(cur.bc[2]),
		.box_a_half_x(cur.ah[0]), .box_a_half_y(cur.ah[1]), .box_a_half_z(cur.ah[2]),
		.box_b_half_x(cur.bh[0]), .box_b_half_y(cur.bh[1]), .box_b_half_z(cur.bh[2]),
		.out_valid(out_valid), .out_ready(out_ready), .hit(hit),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.contact_a_x(contact_a_x), .contact_a_y(contact_a_y),
		.contact_a_z(contact_a_z),
		.contact_b_x(contact_b_x), .contact_b_y(contact_b_y),
		.contact_b_z(contact_b_z)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		contact_t got;
		if (arst_n && in_valid && in_ready)
			board.note_request(cur);
		if (arst_n && out_valid && out_ready) begin
			got.hit = hit;
			got.nrm[0] = normal_x;
			got.nrm[1] = normal_y;
			got.nrm[2] = normal_z;
			got.ca[0] = contact_a_x;
			got.ca[1] = contact_a_y;
			got.ca[2] = contact_a_z;
			got.cb[0] = contact_b_x;
			got.cb[1] = contact_b_y;
			got.cb[2] = contact_b_z;
			board.check_result(got);
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= 4000) begin
			$display("tb_aabb_pair_contact: errors");
			$finish;
		end
	end

	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 0;
				repeat (300) @(negedge clk);
				hold_req = 0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_ready = 0;
				repeat ($urandom_range(1, 8) - 1) @(negedge clk);
			end else
				out_ready = 1;
		end
	end

	task automatic send_pair(box_pair_t p);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			@(negedge clk);
			in_valid = 0;
			repeat ($urandom_range(1, 8) - 1) @(negedge clk);
		end
		@(negedge clk);
		cur = p;
		in_valid = 1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	function automatic box_pair_t random_pair();
		box_pair_t p;
		int mode;
		longint sum, d;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++) begin
			p.bc[i] = $urandom;
			case ($urandom_range(0, 3))
				0: p.ah[i] = HALF_W'($urandom);
				1: p.ah[i] = HALF_W'($urandom_range(0, 1 << 20));
				2: p.ah[i] = HALF_W'($urandom_range(0, 1 << 26));
				default: p.ah[i] = HALF_W'($urandom_range(0, 255));
			endcase
			if (mode < 2)
				p.bh[i] = HALF_W'($urandom);
			else
				p.bh[i] = HALF_W'($urandom_range(0, 1 << ($urandom_range(4, 30))));
			sum = longint'(p.ah[i]) + longint'(p.bh[i]);
			if (mode < 2)
				p.ac[i] = $urandom;
			else begin
				case ($urandom_range(0, 5))
					0: d = sum;
					1: d = -sum;
					2: d = sum + 1;
					3: d = 0;
					default: d = longint'($urandom_range(0, 32'hffff_ffff)) % (sum + 1);
				endcase
				if ($urandom_range(0, 1))
					d = -d;
				p.ac[i] = COORD_W'(longint'(p.bc[i]) + d);
			end
		end
		return p;
	endfunction

	task automatic send_directed();
		box_pair_t p;
		for (int k = 0; k < 12; k++) begin
			for (int i = 0; i < 3; i++) begin
				p.ac[i] = 0;
				p.bc[i] = 0;
				p.ah[i] = 0;
				p.bh[i] = 0;
			end
			case (k)
				1: for (int i = 0; i < 3; i++) begin
					p.ac[i] = 32'h7fff_ffff;
					p.bc[i] = 32'h8000_0000;
					p.ah[i] = '1;
					p.bh[i] = '1;
				end
				2: for (int i = 0; i < 3; i++) begin
					p.ac[i] = 32'h7fff_fffe;
					p.bc[i] = 32'h8000_0000;
					p.ah[i] = '1;
					p.bh[i] = '1;
				end
				3: for (int i = 0; i < 3; i++) begin
					p.ac[i] = 32'h8000_0000;
					p.bc[i] = 32'h7fff_fffe;
					p.ah[i] = '1;
					p.bh[i] = '1;
				end
				4, 5, 6: begin
					p.ac[k - 4] = 32'h0003_0000;
					p.ah[k - 4] = 31'h0001_0000;
					p.bh[k - 4] = 31'h0002_0000;
				end
				7: begin
					p.ac[0] = 32'h0003_0001;
					p.ah[0] = 31'h0001_0000;
					p.bh[0] = 31'h0002_0000;
				end
				8: for (int i = 0; i < 3; i++) begin
					p.ac[i] = -32'sh0001_0000;
					p.ah[i] = 31'h0001_0000;
					p.bh[i] = 31'h0001_0000;
				end
				9: for (int i = 0; i < 3; i++) begin
					p.ac[i] = 32'h1234_5678;
					p.bc[i] = 32'h1234_5678;
					p.ah[i] = '1;
					p.bh[i] = '1;
				end
				10: begin
					p.ac[0] = 1;
					p.ac[1] = -1;
					p.ah[0] = '1;
					p.ah[1] = '1;
					p.ah[2] = '1;
				end
				11: for (int i = 0; i < 3; i++) begin
					p.ac[i] = i * 32'h0100_0000 - 32'h0080_0000;
					p.ah[i] = '1;
					p.bh[i] = 31'h5555_5555;
				end
				default: ;
			endcase
			send_pair(p);
		end
	endtask

	initial begin
		board = new();
		quiet = 0;
		hold_req = 0;
		idle_cycles = 0;
		in_valid = 0;
		for (int i = 0; i < 3; i++) begin
			cur.ac[i] = 0;
			cur.bc[i] = 0;
			cur.ah[i] = 0;
			cur.bh[i] = 0;
		end
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_directed();
		for (int n = 0; n < 1750; n++) begin
			if (n == 500)
				hold_req = 1;
			if (n == 1000) begin
				@(negedge clk);
				in_valid = 0;
				while (board.pending.size() != 0)
					@(negedge clk);
			end
			if (n == 1500)
				quiet = 1;
			send_pair(random_pair());
		end
		@(negedge clk);
		in_valid = 0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("tb_aabb_pair_contact: clean");
		else
			$display("tb_aabb_pair_contact: errors");
		$finish;
	end

endmodule

[aabb_pair_contact.f]
rtl/core/apc_pkg.sv
rtl/core/apc_front.sv
rtl/core/apc_norm.sv
rtl/core/apc_contact.sv
rtl/core/aabb_pair_contact.sv
sim/tb_aabb_pair_contact.sv
